@@ src/clbu_pkg.sv @@
package clbu_pkg;

	// Fixed field widths
	localparam int PIDX_W     = 12;
	localparam int COORD_W    = 5;
	localparam int CFG_DATA_W = 6;
	localparam int CFG_IDX_W  = 1;

	// Action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_MOVE   = 1'b1;

	// Result status codes
	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_SAME_BOX  = 2'd1;
	localparam logic [1:0] STAT_LINK_ERR  = 2'd2;
	localparam logic [1:0] STAT_OUT_RANGE = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BOXES_ACROSS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOXES_DOWN   = 1'd1;

	typedef struct packed {
		logic               action;
		logic [PIDX_W-1:0]  particle_index;
		logic [COORD_W-1:0] target_box_x;
		logic [COORD_W-1:0] target_box_y;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [COORD_W-1:0] former_box_x;
		logic [COORD_W-1:0] former_box_y;
	} result_t;

endpackage

@@ src/clbu_ram.sv @@
module clbu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port (read-first)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ src/cell_list_bin_update.sv @@
// Channel   Direction  Signals                                  Content
// item      in         item_valid / item_ready / item           action, particle, target box
// result    out        result_valid / result_ready / result     status, former box
// cfg       in         cfg_valid / cfg_ready / cfg_index, cfg_data   box limits (x, y)
//
// One item at a time; the state lives in a head RAM and a particle RAM (links + box),
// both with registered reads, and every link update is a read followed by a write.
// Out-of-range and same-box items skip the link updates; a broken link ends a move
// early with a link-error status.
// After reset the head RAM is swept to empty, one entry per box, with item_ready
// low; cfg writes are taken at any time.
// A stalled result holds in the output register; the next item is taken meanwhile.
module cell_list_bin_update #(
	parameter int MAX_PARTICLES = 4096,
	parameter int GRID_X        = 32,
	parameter int GRID_Y        = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  clbu_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output clbu_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [clbu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [clbu_pkg::CFG_DATA_W-1:0] cfg_data
);
	import clbu_pkg::*;

	localparam int NUM_BOXES = GRID_X * GRID_Y;
	localparam int BW        = NUM_BOXES > 1 ? $clog2(NUM_BOXES) : 1;
	localparam int PW        = $clog2(MAX_PARTICLES);
	localparam int LW        = $clog2(MAX_PARTICLES + 1);
	localparam int PWORD_W   = 2 * LW + 2 * COORD_W;
	localparam logic [LW-1:0] NIL = LW'(MAX_PARTICLES);

	typedef enum logic [12:0] {
		S_CLEAR     = 13'b0000000000001,
		S_IDLE      = 13'b0000000000010,
		S_MV_PART   = 13'b0000000000100,
		S_MV_HEAD   = 13'b0000000001000,
		S_UN_NXT_RD = 13'b0000000010000,
		S_UN_NXT_WR = 13'b0000000100000,
		S_UN_PRV_RD = 13'b0000001000000,
		S_UN_PRV_WR = 13'b0000010000000,
		S_LK_RD     = 13'b0000100000000,
		S_LK_WR     = 13'b0001000000000,
		S_FT_RD     = 13'b0010000000000,
		S_FT_WR     = 13'b0100000000000,
		S_RESP      = 13'b1000000000000
	} state_t;

	// Linear box number y*GRID_X + x
	function automatic logic [BW-1:0] box_of(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		logic [15:0] lin;
		lin = 16'(y) * 16'(GRID_X) + 16'(x);
		return lin[BW-1:0];
	endfunction

	state_t state_q, state_d;
	logic [BW-1:0]         clr_q;
	logic [CFG_DATA_W-1:0] across_q, down_q;
	logic                  result_valid_q;
	result_t               result_q;

	// Per-item working registers
	logic [PW-1:0]      pi_q;
	logic [COORD_W-1:0] tx_q, ty_q;
	logic [BW-1:0]      tgt_q, old_box_q;
	logic [LW-1:0]      nxt_q, prv_q, unl_prev_q, first_q;
	result_t            res_q;

	// RAM ports
	logic              h_we, p_we;
	logic [BW-1:0]     h_waddr, h_raddr;
	logic [LW-1:0]     h_wdata, h_rdata;
	logic [PW-1:0]     p_waddr, p_raddr;
	logic [PWORD_W-1:0] p_wdata, p_rdata;

	// Particle word fields
	logic [LW-1:0]      pr_next, pr_prev;
	logic [COORD_W-1:0] pr_x, pr_y;

	logic          go, out_free, bad_in, same_box, first_live;
	logic [BW-1:0] tgt_in, old_in;

	assign pr_next = p_rdata[LW-1:0];
	assign pr_prev = p_rdata[2*LW-1:LW];
	assign pr_x    = p_rdata[2*LW+COORD_W-1:2*LW];
	assign pr_y    = p_rdata[2*LW+2*COORD_W-1:2*LW+COORD_W];

	assign item_ready   = (state_q == S_IDLE);
	assign go           = item_valid && item_ready;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || result_ready;

	// Input range check against effective grid and particle count
	assign bad_in = (item.target_box_x >= COORD_W'(across_q) && across_q < 6'd32)
		|| (item.target_box_y >= COORD_W'(down_q) && down_q < 6'd32)
		|| (9'(item.target_box_x) >= 9'(GRID_X))
		|| (9'(item.target_box_y) >= 9'(GRID_Y))
		|| (17'(item.particle_index) >= 17'(MAX_PARTICLES));
	assign tgt_in     = box_of(item.target_box_x, item.target_box_y);
	assign old_in     = box_of(pr_x, pr_y);
	assign same_box   = (pr_x == tx_q) && (pr_y == ty_q);
	assign first_live = (h_rdata < NIL);

	clbu_ram #(.WIDTH(LW), .DEPTH(NUM_BOXES)) u_head_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	clbu_ram #(.WIDTH(PWORD_W), .DEPTH(MAX_PARTICLES)) u_part_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	// Next state and RAM access per state
	always_comb begin
		state_d = state_q;
		h_we    = 1'b0;
		h_waddr = tgt_q;
		h_wdata = LW'(pi_q);
		h_raddr = tgt_q;
		p_we    = 1'b0;
		p_waddr = pi_q;
		p_wdata = p_rdata;
		p_raddr = pi_q;
		case (state_q)
			S_CLEAR: begin
				h_we    = 1'b1;
				h_waddr = clr_q;
				h_wdata = NIL;
				if (clr_q == BW'(NUM_BOXES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				h_raddr = tgt_in;
				p_raddr = PW'(item.particle_index);
				if (go) begin
					if (bad_in) begin
						state_d = S_RESP;
					end else if (item.action == ACT_INSERT) begin
						state_d = S_LK_WR;
					end else begin
						state_d = S_MV_PART;
					end
				end
			end
			S_MV_PART: begin
				h_raddr = old_in;
				state_d = same_box ? S_RESP : S_MV_HEAD;
			end
			S_MV_HEAD: begin
				if (h_rdata == LW'(pi_q)) begin
					// particle heads its old box: head takes its successor
					h_we    = 1'b1;
					h_waddr = old_box_q;
					h_wdata = nxt_q;
					state_d = (nxt_q < NIL) ? S_UN_PRV_RD : S_LK_RD;
				end else if (prv_q >= NIL) begin
					state_d = S_RESP;
				end else begin
					state_d = S_UN_NXT_RD;
				end
			end
			S_UN_NXT_RD: begin
				p_raddr = PW'(prv_q);
				state_d = S_UN_NXT_WR;
			end
			S_UN_NXT_WR: begin
				p_we    = 1'b1;
				p_waddr = PW'(prv_q);
				p_wdata = {p_rdata[PWORD_W-1:LW], nxt_q};
				state_d = (nxt_q < NIL) ? S_UN_PRV_RD : S_LK_RD;
			end
			S_UN_PRV_RD: begin
				p_raddr = PW'(nxt_q);
				state_d = S_UN_PRV_WR;
			end
			S_UN_PRV_WR: begin
				p_we    = 1'b1;
				p_waddr = PW'(nxt_q);
				p_wdata = {pr_y, pr_x, unl_prev_q, pr_next};
				state_d = S_LK_RD;
			end
			S_LK_RD: begin
				state_d = S_LK_WR;
			end
			S_LK_WR: begin
				// head of target box now points at the particle
				h_we    = 1'b1;
				p_we    = 1'b1;
				p_wdata = {ty_q, tx_q, NIL, h_rdata};
				state_d = first_live ? S_FT_RD : S_RESP;
			end
			S_FT_RD: begin
				p_raddr = PW'(first_q);
				state_d = S_FT_WR;
			end
			S_FT_WR: begin
				p_we    = 1'b1;
				p_waddr = PW'(first_q);
				p_wdata = {pr_y, pr_x, LW'(pi_q), pr_next};
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			across_q       <= 6'd32;
			down_q         <= 6'd32;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BOXES_ACROSS: across_q <= cfg_data;
					REG_BOXES_DOWN:   down_q   <= cfg_data;
					default:          ;
				endcase
			end
			if (state_q == S_RESP && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pi_q  <= PW'(item.particle_index);
				tx_q  <= item.target_box_x;
				ty_q  <= item.target_box_y;
				tgt_q <= tgt_in;
				res_q <= '{status: bad_in ? STAT_OUT_RANGE : STAT_DONE,
					former_box_x: '0, former_box_y: '0};
			end
			S_MV_PART: begin
				nxt_q              <= pr_next;
				prv_q              <= pr_prev;
				old_box_q          <= old_in;
				res_q.former_box_x <= pr_x;
				res_q.former_box_y <= pr_y;
				if (same_box) begin
					res_q.status <= STAT_SAME_BOX;
				end
			end
			S_MV_HEAD: begin
				unl_prev_q <= NIL;
				if (h_rdata != LW'(pi_q) && prv_q >= NIL) begin
					res_q.status <= STAT_LINK_ERR;
				end
			end
			S_UN_NXT_WR: begin
				unl_prev_q <= prv_q;
			end
			S_LK_WR: begin
				first_q <= h_rdata;
			end
			S_RESP: begin
				if (out_free) begin
					result_q <= res_q;
				end
			end
			default: ;
		endcase
	end
endmodule

@@ src/clbu_check.sv @@
module clbu_check (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_ready,
	input logic                 result_valid,
	input logic                 result_ready,
	input clbu_pkg::result_t    result
);
	import clbu_pkg::*;

	logic [1:0] open_q;
	logic       item_beat, result_beat;

	assign item_beat   = item_valid && item_ready;
	assign result_beat = result_valid && result_ready;

	// Items taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 2'd0;
		end else if (item_beat && !result_beat) begin
			open_q <= open_q + 2'd1;
		end else if (result_beat && !item_beat) begin
			open_q <= open_q - 2'd1;
		end
	end

	// A stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// No result without an item behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> open_q != 2'd0)
		else $error("result with no item pending");

	// At most one answered item waits while the next one is in work
	a_one_queued: assert property (@(posedge clk) disable iff (!arst_n)
		item_beat |-> open_q != 2'd2)
		else $error("item taken with two results owed");

	// An item is worked alone
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_beat |=> !item_ready)
		else $error("item ready right after an item beat");

	// Out-of-range results carry no former box
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == STAT_OUT_RANGE |->
			result.former_box_x == '0 && result.former_box_y == '0)
		else $error("out-of-range result with former box set");
endmodule

bind cell_list_bin_update clbu_check u_clbu_check (.*);
